FILE: hdl/tid_pkg.sv
// Thumb instruction decoder package: instruction class codes, opcode field
// constants and the decoded field bundle shared by the pipeline stages.
// No dependencies.
`default_nettype none

package tid_pkg;

  typedef enum logic [4:0] {
    ClsMoveShift     = 5'd0,
    ClsAddReg        = 5'd1,
    ClsSubReg        = 5'd2,
    ClsMovImm        = 5'd3,
    ClsCmpImm        = 5'd4,
    ClsAddImm        = 5'd5,
    ClsSubImm        = 5'd6,
    ClsAluOp         = 5'd7,
    ClsHiRegOp       = 5'd8,
    ClsPcRelLoad     = 5'd9,
    ClsStoreImmOff   = 5'd10,
    ClsLoadImmOff    = 5'd11,
    ClsStoreRegOff   = 5'd12,
    ClsLoadRegOff    = 5'd13,
    ClsStoreHalf     = 5'd14,
    ClsLoadHalf      = 5'd15,
    ClsSignHalf      = 5'd16,
    ClsSpRelStore    = 5'd17,
    ClsSpRelLoad     = 5'd18,
    ClsOffsetSp      = 5'd19,
    ClsLoadAddr      = 5'd20,
    ClsLoadMulti     = 5'd21,
    ClsStoreMulti    = 5'd22,
    ClsPush          = 5'd23,
    ClsPop           = 5'd24,
    ClsBranch        = 5'd25,
    ClsCondBranch    = 5'd26,
    ClsLongBrPrep    = 5'd27,
    ClsLongBranch    = 5'd28,
    ClsLongBlx       = 5'd29
  } class_e;

  localparam logic [1:0] ShiftLsl     = 2'd0;
  localparam logic [1:0] AddSubGroup  = 2'd3;
  localparam logic [1:0] HiOpBx       = 2'd3;
  localparam logic [1:0] PushPopSel   = 2'd2;
  localparam logic [3:0] CondSwi      = 4'hF;

  typedef struct packed {
    logic [3:0] dest_reg;
    logic [3:0] src_reg;
    logic [2:0] third_reg;
    logic [3:0] sub_op;
    logic       imm_operand;
    logic       byte_access;
    logic [7:0] reg_mask;
    logic       extra_reg;
    logic       is_swi;
    logic       base_writeback;
  } fields_t;

endpackage

`default_nettype wire

FILE: hdl/thumb_instruction_decoder.sv
// Thumb instruction decoder top level: four-stage pipeline around the class
// and field decoders. Depends on tid_pkg, tid_classify and tid_field_dec.
//
// Usage:
//   Input channel: in_valid_i / in_ready_o carry one 16-bit Thumb halfword
//   (instr_word_i) per transfer. Output channel: out_valid_o / out_ready_i
//   carry one decoded result per input transfer, in order.
//   Stages: input register, class register, field register, output register
//   (immediate formed in the last stage). Throughput is one halfword per
//   cycle while the receiver keeps out_ready_i high.
//   Each stage holds its item until the next stage frees up, so when the
//   receiver stalls the pipeline fills, up to four items, and in_ready_o
//   drops only once every stage is occupied. Bubbles collapse on the way.
//   Reset clears all stage valid bits; the block then accepts at once.
`default_nettype none

module thumb_instruction_decoder (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [15:0]        instr_word_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [4:0]              instr_class_o,
  output logic [3:0]              dest_reg_o,
  output logic [3:0]              src_reg_o,
  output logic [2:0]              third_reg_o,
  output logic [3:0]              sub_op_o,
  output logic signed [22:0]      immediate_o,
  output logic                    imm_operand_o,
  output logic                    byte_access_o,
  output logic [7:0]              reg_mask_o,
  output logic                    extra_reg_o,
  output logic                    is_swi_o,
  output logic                    base_writeback_o
);

  logic v1_q, v2_q, v3_q, vo_q;
  logic rdy1, rdy2, rdy3, rdyo;

  logic [15:0] w1_q, w2_q, w3_q;
  tid_pkg::class_e cls_d, cls2_q, cls3_q;
  tid_pkg::fields_t fld_d, fld3_q, fld_o_q;
  tid_pkg::class_e cls_o_q;
  logic [22:0] imm_d, imm_o_q;

  assign rdyo       = ~vo_q | out_ready_i;
  assign rdy3       = ~v3_q | rdyo;
  assign rdy2       = ~v2_q | rdy3;
  assign rdy1       = ~v1_q | rdy2;
  assign in_ready_o = rdy1;

  tid_classify u_classify (
    .word_i (w1_q),
    .cls_o  (cls_d)
  );

  tid_field_dec u_field_dec (
    .word_i   (w2_q),
    .cls_i    (cls2_q),
    .fields_o (fld_d)
  );

  always_comb begin
    imm_d = '0;
    case (cls3_q)
      tid_pkg::ClsMoveShift: begin
        if ((w3_q[12:11] != tid_pkg::ShiftLsl) && (w3_q[10:6] == 5'd0)) begin
          imm_d = 23'd32;
        end else begin
          imm_d = {18'd0, w3_q[10:6]};
        end
      end
      tid_pkg::ClsAddReg, tid_pkg::ClsSubReg: begin
        imm_d = w3_q[10] ? {20'd0, w3_q[8:6]} : 23'd0;
      end
      tid_pkg::ClsMovImm, tid_pkg::ClsCmpImm, tid_pkg::ClsAddImm, tid_pkg::ClsSubImm: begin
        imm_d = {15'd0, w3_q[7:0]};
      end
      tid_pkg::ClsPcRelLoad, tid_pkg::ClsSpRelStore, tid_pkg::ClsSpRelLoad,
      tid_pkg::ClsLoadAddr: begin
        imm_d = {13'd0, w3_q[7:0], 2'b00};
      end
      tid_pkg::ClsStoreImmOff, tid_pkg::ClsLoadImmOff: begin
        imm_d = w3_q[12] ? {18'd0, w3_q[10:6]} : {16'd0, w3_q[10:6], 2'b00};
      end
      tid_pkg::ClsStoreHalf, tid_pkg::ClsLoadHalf: begin
        imm_d = {17'd0, w3_q[10:6], 1'b0};
      end
      tid_pkg::ClsOffsetSp: begin
        if (w3_q[7]) begin
          imm_d = 23'd0 - {14'd0, w3_q[6:0], 2'b00};
        end else begin
          imm_d = {14'd0, w3_q[6:0], 2'b00};
        end
      end
      tid_pkg::ClsCondBranch: begin
        if (w3_q[11:8] == tid_pkg::CondSwi) begin
          imm_d = {15'd0, w3_q[7:0]};
        end else begin
          imm_d = {{14{w3_q[7]}}, w3_q[7:0], 1'b0};
        end
      end
      tid_pkg::ClsBranch: begin
        imm_d = {{11{w3_q[10]}}, w3_q[10:0], 1'b0};
      end
      tid_pkg::ClsLongBrPrep: begin
        imm_d = {w3_q[10:0], 12'd0};
      end
      tid_pkg::ClsLongBranch, tid_pkg::ClsLongBlx: begin
        imm_d = {11'd0, w3_q[10:0], 1'b0};
      end
      default: begin
        imm_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdyo) vo_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      w1_q <= instr_word_i;
    end
    if (rdy2 && v1_q) begin
      w2_q   <= w1_q;
      cls2_q <= cls_d;
    end
    if (rdy3 && v2_q) begin
      w3_q   <= w2_q;
      cls3_q <= cls2_q;
      fld3_q <= fld_d;
    end
    if (rdyo && v3_q) begin
      cls_o_q <= cls3_q;
      fld_o_q <= fld3_q;
      imm_o_q <= imm_d;
    end
  end

  assign out_valid_o      = vo_q;
  assign instr_class_o    = 5'(cls_o_q);
  assign dest_reg_o       = fld_o_q.dest_reg;
  assign src_reg_o        = fld_o_q.src_reg;
  assign third_reg_o      = fld_o_q.third_reg;
  assign sub_op_o         = fld_o_q.sub_op;
  assign immediate_o      = $signed(imm_o_q);
  assign imm_operand_o    = fld_o_q.imm_operand;
  assign byte_access_o    = fld_o_q.byte_access;
  assign reg_mask_o       = fld_o_q.reg_mask;
  assign extra_reg_o      = fld_o_q.extra_reg;
  assign is_swi_o         = fld_o_q.is_swi;
  assign base_writeback_o = fld_o_q.base_writeback;

endmodule

`default_nettype wire

FILE: hdl/tid_classify.sv
// Instruction class decode from the opcode bits of a Thumb halfword.
// Depends on tid_pkg.
`default_nettype none

module tid_classify (
  input  wire logic [15:0]     word_i,
  output tid_pkg::class_e      cls_o
);

  always_comb begin
    cls_o = tid_pkg::ClsLongBrPrep;
    if (word_i[15:13] == 3'b000) begin
      if (word_i[12:11] != tid_pkg::AddSubGroup) begin
        cls_o = tid_pkg::ClsMoveShift;
      end else begin
        cls_o = word_i[9] ? tid_pkg::ClsSubReg : tid_pkg::ClsAddReg;
      end
    end else if (word_i[15:13] == 3'b001) begin
      cls_o = tid_pkg::class_e'(5'(tid_pkg::ClsMovImm) + {3'b000, word_i[12:11]});
    end else if (word_i[15:10] == 6'b010000) begin
      cls_o = tid_pkg::ClsAluOp;
    end else if (word_i[15:10] == 6'b010001) begin
      cls_o = tid_pkg::ClsHiRegOp;
    end else if (word_i[15:11] == 5'b01001) begin
      cls_o = tid_pkg::ClsPcRelLoad;
    end else if (word_i[15:12] == 4'b0101) begin
      if (word_i[9]) begin
        cls_o = tid_pkg::ClsSignHalf;
      end else begin
        cls_o = word_i[11] ? tid_pkg::ClsLoadRegOff : tid_pkg::ClsStoreRegOff;
      end
    end else if (word_i[15:13] == 3'b011) begin
      cls_o = word_i[11] ? tid_pkg::ClsLoadImmOff : tid_pkg::ClsStoreImmOff;
    end else if (word_i[15:12] == 4'b1000) begin
      cls_o = word_i[11] ? tid_pkg::ClsLoadHalf : tid_pkg::ClsStoreHalf;
    end else if (word_i[15:12] == 4'b1001) begin
      cls_o = word_i[11] ? tid_pkg::ClsSpRelLoad : tid_pkg::ClsSpRelStore;
    end else if (word_i[15:12] == 4'b1010) begin
      cls_o = tid_pkg::ClsLoadAddr;
    end else if (word_i[15:12] == 4'b1011) begin
      if (word_i[10:9] == tid_pkg::PushPopSel) begin
        cls_o = word_i[11] ? tid_pkg::ClsPop : tid_pkg::ClsPush;
      end else begin
        cls_o = tid_pkg::ClsOffsetSp;
      end
    end else if (word_i[15:12] == 4'b1100) begin
      cls_o = word_i[11] ? tid_pkg::ClsLoadMulti : tid_pkg::ClsStoreMulti;
    end else if (word_i[15:12] == 4'b1101) begin
      cls_o = tid_pkg::ClsCondBranch;
    end else if (word_i[15:11] == 5'b11100) begin
      cls_o = tid_pkg::ClsBranch;
    end else if (word_i[15:11] == 5'b11101) begin
      cls_o = tid_pkg::ClsLongBlx;
    end else begin
      cls_o = word_i[11] ? tid_pkg::ClsLongBranch : tid_pkg::ClsLongBrPrep;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/tid_field_dec.sv
// Register, sub-operation and flag extraction for a classified Thumb halfword.
// Depends on tid_pkg.
`default_nettype none

module tid_field_dec (
  input  wire logic [15:0]     word_i,
  input  wire tid_pkg::class_e cls_i,
  output tid_pkg::fields_t     fields_o
);

  logic [2:0] lo3, mid3, hi3, r8;

  assign lo3  = word_i[2:0];
  assign mid3 = word_i[5:3];
  assign hi3  = word_i[8:6];
  assign r8   = word_i[10:8];

  always_comb begin
    fields_o = '0;
    case (cls_i)
      tid_pkg::ClsMoveShift: begin
        fields_o.dest_reg = {1'b0, lo3};
        fields_o.src_reg  = {1'b0, mid3};
        fields_o.sub_op   = {2'b00, word_i[12:11]};
      end
      tid_pkg::ClsAddReg, tid_pkg::ClsSubReg: begin
        fields_o.dest_reg    = {1'b0, lo3};
        fields_o.src_reg     = {1'b0, mid3};
        fields_o.imm_operand = word_i[10];
        fields_o.third_reg   = word_i[10] ? 3'd0 : hi3;
      end
      tid_pkg::ClsMovImm, tid_pkg::ClsCmpImm, tid_pkg::ClsAddImm, tid_pkg::ClsSubImm,
      tid_pkg::ClsPcRelLoad, tid_pkg::ClsSpRelStore, tid_pkg::ClsSpRelLoad: begin
        fields_o.dest_reg = {1'b0, r8};
      end
      tid_pkg::ClsLoadAddr: begin
        fields_o.dest_reg  = {1'b0, r8};
        fields_o.extra_reg = word_i[11];
      end
      tid_pkg::ClsAluOp: begin
        fields_o.dest_reg = {1'b0, lo3};
        fields_o.src_reg  = {1'b0, mid3};
        fields_o.sub_op   = word_i[9:6];
      end
      tid_pkg::ClsHiRegOp: begin
        fields_o.dest_reg  = {word_i[7], lo3};
        fields_o.src_reg   = {word_i[6], mid3};
        fields_o.sub_op    = {2'b00, word_i[9:8]};
        fields_o.extra_reg = (word_i[9:8] == tid_pkg::HiOpBx) && word_i[7];
      end
      tid_pkg::ClsStoreRegOff, tid_pkg::ClsLoadRegOff: begin
        fields_o.dest_reg    = {1'b0, lo3};
        fields_o.src_reg     = {1'b0, mid3};
        fields_o.third_reg   = hi3;
        fields_o.byte_access = word_i[10];
      end
      tid_pkg::ClsSignHalf: begin
        fields_o.dest_reg  = {1'b0, lo3};
        fields_o.src_reg   = {1'b0, mid3};
        fields_o.third_reg = hi3;
        fields_o.sub_op    = {2'b00, word_i[11:10]};
      end
      tid_pkg::ClsStoreImmOff, tid_pkg::ClsLoadImmOff: begin
        fields_o.dest_reg    = {1'b0, lo3};
        fields_o.src_reg     = {1'b0, mid3};
        fields_o.byte_access = word_i[12];
      end
      tid_pkg::ClsStoreHalf, tid_pkg::ClsLoadHalf: begin
        fields_o.dest_reg = {1'b0, lo3};
        fields_o.src_reg  = {1'b0, mid3};
      end
      tid_pkg::ClsPush, tid_pkg::ClsPop: begin
        fields_o.reg_mask  = word_i[7:0];
        fields_o.extra_reg = word_i[8];
      end
      tid_pkg::ClsLoadMulti: begin
        fields_o.third_reg      = r8;
        fields_o.reg_mask       = word_i[7:0];
        fields_o.base_writeback = ~word_i[{1'b0, r8}];
      end
      tid_pkg::ClsStoreMulti: begin
        fields_o.third_reg      = r8;
        fields_o.reg_mask       = word_i[7:0];
        fields_o.base_writeback = 1'b1;
      end
      tid_pkg::ClsCondBranch: begin
        fields_o.sub_op = word_i[11:8];
        fields_o.is_swi = (word_i[11:8] == tid_pkg::CondSwi);
      end
      default: begin
        fields_o = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: tb/sv/thumb_instruction_decoder_tb.sv
// Testbench for thumb_instruction_decoder: directed and random Thumb halfwords
// are decoded by a scoreboard class and every output transfer is checked field
// by field in order. Depends on tid_pkg and the decoder RTL.
`timescale 1ns / 1ps

module thumb_instruction_decoder_tb;

  typedef struct packed {
    tid_pkg::class_e  cls;
    tid_pkg::fields_t f;
    logic [22:0]      imm;
  } thumb_dec_t;

  class decode_board;
    thumb_dec_t  expected_q[$];
    logic [15:0] word_q[$];
    logic [29:0] seen_classes;
    int unsigned mismatch_cnt;
    int unsigned decoded_cnt;

    function new();
      seen_classes = '0;
      mismatch_cnt = 0;
      decoded_cnt  = 0;
    endfunction

    function thumb_dec_t decode_halfword(logic [15:0] w);
      thumb_dec_t  d;
      logic [22:0] mag;
      d   = '0;
      mag = {14'b0, w[6:0], 2'b0};
      casez (w[15:10])
        6'b000???: begin
          d.f.dest_reg = {1'b0, w[2:0]};
          d.f.src_reg  = {1'b0, w[5:3]};
          if (w[12:11] != tid_pkg::AddSubGroup) begin
            d.cls      = tid_pkg::ClsMoveShift;
            d.f.sub_op = {2'b0, w[12:11]};
            d.imm      = {18'b0, w[10:6]};
            // LSR/ASR by zero encodes a shift of 32
            if (w[12:11] != tid_pkg::ShiftLsl && w[10:6] == 5'd0) d.imm = 23'd32;
          end else begin
            d.cls           = w[9] ? tid_pkg::ClsSubReg : tid_pkg::ClsAddReg;
            d.f.imm_operand = w[10];
            if (w[10]) d.imm = {20'b0, w[8:6]};
            else d.f.third_reg = w[8:6];
          end
        end
        6'b001???: begin
          d.cls        = tid_pkg::class_e'(5'(tid_pkg::ClsMovImm) + {3'b000, w[12:11]});
          d.f.dest_reg = {1'b0, w[10:8]};
          d.imm        = {15'b0, w[7:0]};
        end
        6'b010000: begin
          d.cls        = tid_pkg::ClsAluOp;
          d.f.dest_reg = {1'b0, w[2:0]};
          d.f.src_reg  = {1'b0, w[5:3]};
          d.f.sub_op   = w[9:6];
        end
        6'b010001: begin
          d.cls         = tid_pkg::ClsHiRegOp;
          d.f.sub_op    = {2'b0, w[9:8]};
          d.f.dest_reg  = {w[7], w[2:0]};
          d.f.src_reg   = {w[6], w[5:3]};
          d.f.extra_reg = (w[9:8] == tid_pkg::HiOpBx) && w[7];
        end
        6'b01001?: begin
          d.cls        = tid_pkg::ClsPcRelLoad;
          d.f.dest_reg = {1'b0, w[10:8]};
          d.imm        = {13'b0, w[7:0], 2'b0};
        end
        6'b0101??: begin
          d.f.dest_reg  = {1'b0, w[2:0]};
          d.f.src_reg   = {1'b0, w[5:3]};
          d.f.third_reg = w[8:6];
          if (w[9]) begin
            d.cls      = tid_pkg::ClsSignHalf;
            d.f.sub_op = {2'b0, w[11:10]};
          end else begin
            d.cls           = w[11] ? tid_pkg::ClsLoadRegOff : tid_pkg::ClsStoreRegOff;
            d.f.byte_access = w[10];
          end
        end
        6'b011???: begin
          d.cls           = w[11] ? tid_pkg::ClsLoadImmOff : tid_pkg::ClsStoreImmOff;
          d.f.dest_reg    = {1'b0, w[2:0]};
          d.f.src_reg     = {1'b0, w[5:3]};
          d.f.byte_access = w[12];
          d.imm           = w[12] ? {18'b0, w[10:6]} : {16'b0, w[10:6], 2'b0};
        end
        6'b1000??: begin
          d.cls        = w[11] ? tid_pkg::ClsLoadHalf : tid_pkg::ClsStoreHalf;
          d.f.dest_reg = {1'b0, w[2:0]};
          d.f.src_reg  = {1'b0, w[5:3]};
          d.imm        = {17'b0, w[10:6], 1'b0};
        end
        6'b1001??: begin
          d.cls        = w[11] ? tid_pkg::ClsSpRelLoad : tid_pkg::ClsSpRelStore;
          d.f.dest_reg = {1'b0, w[10:8]};
          d.imm        = {13'b0, w[7:0], 2'b0};
        end
        6'b1010??: begin
          d.cls         = tid_pkg::ClsLoadAddr;
          d.f.dest_reg  = {1'b0, w[10:8]};
          d.imm         = {13'b0, w[7:0], 2'b0};
          d.f.extra_reg = w[11];
        end
        6'b1011??: begin
          if (w[10:9] == tid_pkg::PushPopSel) begin
            d.cls         = w[11] ? tid_pkg::ClsPop : tid_pkg::ClsPush;
            d.f.reg_mask  = w[7:0];
            d.f.extra_reg = w[8];
          end else begin
            // all other 0xBxxx words decode as SP adjust
            d.cls = tid_pkg::ClsOffsetSp;
            d.imm = w[7] ? 23'd0 - mag : mag;
          end
        end
        6'b1100??: begin
          d.f.third_reg = w[10:8];
          d.f.reg_mask  = w[7:0];
          if (w[11]) begin
            d.cls              = tid_pkg::ClsLoadMulti;
            d.f.base_writeback = !w[w[10:8]];
          end else begin
            d.cls              = tid_pkg::ClsStoreMulti;
            d.f.base_writeback = 1'b1;
          end
        end
        6'b1101??: begin
          d.cls      = tid_pkg::ClsCondBranch;
          d.f.sub_op = w[11:8];
          if (w[11:8] == tid_pkg::CondSwi) begin
            d.f.is_swi = 1'b1;
            d.imm      = {15'b0, w[7:0]};
          end else begin
            d.imm = {{14{w[7]}}, w[7:0], 1'b0};
          end
        end
        6'b11100?: begin
          d.cls = tid_pkg::ClsBranch;
          d.imm = {{11{w[10]}}, w[10:0], 1'b0};
        end
        6'b11101?: begin
          d.cls = tid_pkg::ClsLongBlx;
          d.imm = {11'b0, w[10:0], 1'b0};
        end
        default: begin
          if (w[11]) begin
            d.cls = tid_pkg::ClsLongBranch;
            d.imm = {11'b0, w[10:0], 1'b0};
          end else begin
            d.cls = tid_pkg::ClsLongBrPrep;
            d.imm = {w[10:0], 12'b0};
          end
        end
      endcase
      return d;
    endfunction

    function void note_halfword(logic [15:0] w);
      thumb_dec_t d;
      d = decode_halfword(w);
      seen_classes[d.cls] = 1'b1;
      expected_q.push_back(d);
      word_q.push_back(w);
    endfunction

    function void report(logic [15:0] w, string name, logic [22:0] exp_v,
                         logic [22:0] act_v);
      if (act_v !== exp_v) begin
        mismatch_cnt++;
        $display("%0t: word %h %s expected %0h actual %0h", $time, w, name,
                 exp_v, act_v);
      end
    endfunction

    function void check_decoded(thumb_dec_t act);
      thumb_dec_t  e;
      logic [15:0] w;
      if (expected_q.size() == 0) begin
        mismatch_cnt++;
        $display("%0t: unexpected output transfer, expected none actual class %0d",
                 $time, act.cls);
        return;
      end
      e = expected_q.pop_front();
      w = word_q.pop_front();
      decoded_cnt++;
      report(w, "instr_class", e.cls, act.cls);
      report(w, "dest_reg", e.f.dest_reg, act.f.dest_reg);
      report(w, "src_reg", e.f.src_reg, act.f.src_reg);
      report(w, "third_reg", e.f.third_reg, act.f.third_reg);
      report(w, "sub_op", e.f.sub_op, act.f.sub_op);
      report(w, "immediate", e.imm, act.imm);
      report(w, "imm_operand", e.f.imm_operand, act.f.imm_operand);
      report(w, "byte_access", e.f.byte_access, act.f.byte_access);
      report(w, "reg_mask", e.f.reg_mask, act.f.reg_mask);
      report(w, "extra_reg", e.f.extra_reg, act.f.extra_reg);
      report(w, "is_swi", e.f.is_swi, act.f.is_swi);
      report(w, "base_writeback", e.f.base_writeback, act.f.base_writeback);
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [15:0]        instr_word_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [4:0]         instr_class_o;
  logic [3:0]         dest_reg_o;
  logic [3:0]         src_reg_o;
  logic [2:0]         third_reg_o;
  logic [3:0]         sub_op_o;
  logic signed [22:0] immediate_o;
  logic               imm_operand_o;
  logic               byte_access_o;
  logic [7:0]         reg_mask_o;
  logic               extra_reg_o;
  logic               is_swi_o;
  logic               base_writeback_o;

  thumb_dec_t  dut_dec;
  decode_board board;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  bit          hold_req;
  int unsigned hold_left;
  logic [15:0] directed_words [26];

  thumb_instruction_decoder i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .instr_word_i     (instr_word_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .instr_class_o    (instr_class_o),
    .dest_reg_o       (dest_reg_o),
    .src_reg_o        (src_reg_o),
    .third_reg_o      (third_reg_o),
    .sub_op_o         (sub_op_o),
    .immediate_o      (immediate_o),
    .imm_operand_o    (imm_operand_o),
    .byte_access_o    (byte_access_o),
    .reg_mask_o       (reg_mask_o),
    .extra_reg_o      (extra_reg_o),
    .is_swi_o         (is_swi_o),
    .base_writeback_o (base_writeback_o)
  );

  assign dut_dec = {instr_class_o, dest_reg_o, src_reg_o, third_reg_o, sub_op_o,
                    imm_operand_o, byte_access_o, reg_mask_o, extra_reg_o,
                    is_swi_o, base_writeback_o, immediate_o};

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // output check before input note keeps the queue order independent of events
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) board.check_decoded(dut_dec);
      if (in_valid_i && in_ready_o) board.note_halfword(instr_word_i);
    end
  end

  // receiver: random stalls plus one long hold-off when requested
  initial begin
    out_ready_i = 1'b0;
    hold_left   = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 120;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic send_halfword(input logic [15:0] w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    instr_word_i <= w;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // uniform words, sometimes with zeroed fields or steered into the
  // SP-adjust/push/pop and conditional branch groups
  function automatic logic [15:0] random_halfword();
    logic [15:0] w;
    w = 16'($urandom);
    case ($urandom_range(7))
      0: w[10:6] = 5'd0;
      1: w[6:0] = 7'd0;
      2: w[15:12] = 4'hB;
      3: w[15:12] = 4'hD;
      default: ;
    endcase
    return w;
  endfunction

  task automatic run_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                           input int unsigned count);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) send_halfword(random_halfword());
  endtask

  initial begin
    board          = new();
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    instr_word_i   = 16'h0000;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req       = 1'b0;
    directed_words = '{16'h0000, 16'h0800, 16'h1000, 16'h1800, 16'h1FFF, 16'h27FF,
                       16'h3FFF, 16'h43FF, 16'h47FF, 16'h4FFF, 16'h5FFF, 16'h7FFF,
                       16'h6FFF, 16'h8FFF, 16'h9FFF, 16'hAFFF, 16'hB080, 16'hBFFF,
                       16'hB5FF, 16'hBDFF, 16'hC8FF, 16'hCF7F, 16'hDFFF, 16'hE400,
                       16'hF400, 16'hEFFF};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_words[i]) send_halfword(directed_words[i]);
    send_halfword(16'hFFFF);

    run_phase(0, 0, 400);
    run_phase(73, 0, 400);
    run_phase(0, 73, 400);
    run_phase(34, 34, 400);

    // long output hold-off while input keeps coming: pipeline fills and stalls
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req       = 1'b1;
    repeat (40) send_halfword(random_halfword());

    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("Checked %0d decoded halfwords covering %0d of 30 classes,",
             board.decoded_cnt, $countones(board.seen_classes));
    $display("with input gaps, output stalls and a long output hold-off.");
    if (board.mismatch_cnt == 0 && board.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Timeout waiting for decoder transfers");
    $display("Mismatches found");
    $finish;
  end

endmodule
